FILE: rtl/core/jmucc_pkg.sv
// Shared constants, types and helpers for the MCU upsampling and color conversion block.
package jmucc_pkg;

    localparam int BLOCK_SIDE  = 8;
    localparam int SAMPLE_BITS = 12;

    localparam int BLK_BITS    = $clog2(BLOCK_SIDE);
    localparam int IDX_W       = 2 * BLK_BITS;
    localparam int STORE_DEPTH = BLOCK_SIDE * BLOCK_SIDE;
    localparam int COORD_W     = 16;
    localparam int CH_W        = 8;
    localparam int SS_W        = 3;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;

    // Q16 coefficients and arithmetic widths
    localparam int FRAC   = 16;
    localparam int Q_W    = 18;
    localparam int PROD_W = SAMPLE_BITS + Q_W;
    localparam int SUM_W  = SAMPLE_BITS + Q_W + 2;

    localparam logic signed [Q_W-1:0] Q_CR_R = Q_W'(91881);
    localparam logic signed [Q_W-1:0] Q_CB_G = Q_W'(22553);
    localparam logic signed [Q_W-1:0] Q_CR_G = Q_W'(46802);
    localparam logic signed [Q_W-1:0] Q_CB_B = Q_W'(116130);

    localparam logic signed [SAMPLE_BITS:0] Y_OFFSET = (SAMPLE_BITS + 1)'(128);
    localparam logic [CH_W-1:0] CH_MAX = '1;

    // component codes
    localparam logic [1:0] MODE_LUMA = 2'd0;
    localparam logic [1:0] MODE_CB   = 2'd1;
    localparam logic [1:0] MODE_CR   = 2'd2;

    // subsampling codes
    localparam logic [SS_W-1:0] SS_444  = 3'd0;
    localparam logic [SS_W-1:0] SS_422H = 3'd1;
    localparam logic [SS_W-1:0] SS_422V = 3'd2;
    localparam logic [SS_W-1:0] SS_420  = 3'd3;
    localparam logic [SS_W-1:0] SS_GRAY = 3'd4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SUBSAMPLING  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd2;

    localparam logic [COORD_W-1:0] DIM_RESET = COORD_W'(64);

    typedef struct packed {
        logic                          wr_cb;
        logic                          wr_cr;
        logic [IDX_W-1:0]              waddr;
        logic signed [SAMPLE_BITS-1:0] wdata;
        logic [IDX_W-1:0]              raddr;
    } t_mem_req;

    typedef struct packed {
        logic                          valid;
        logic                          gray;
        logic [COORD_W-1:0]            x;
        logic [COORD_W-1:0]            y;
        logic signed [SAMPLE_BITS-1:0] value;
    } t_pix;

    // truncate Q16 toward zero and clamp to the channel range
    function automatic logic [CH_W-1:0] clamp_q16(input logic signed [SUM_W-1:0] v);
        logic [CH_W-1:0] res;
        if (v < 0) begin
            res = '0;
        end else if (v[SUM_W-2:FRAC+CH_W] != '0) begin
            res = CH_MAX;
        end else begin
            res = v[FRAC+CH_W-1:FRAC];
        end
        return res;
    endfunction

endpackage

FILE: rtl/core/jmucc_in_if.sv
// Sample input channel: valid/ready handshake with one decoded sample as payload.
interface jmucc_in_if;
    logic                                    valid;
    logic                                    ready;
    logic [1:0]                              mode;
    logic [1:0]                              block_in_mcu;
    logic [jmucc_pkg::IDX_W-1:0]             sample_index;
    logic signed [jmucc_pkg::SAMPLE_BITS-1:0] sample_value;

    modport source (output valid, mode, block_in_mcu, sample_index, sample_value,
                    input ready);
    modport sink   (input valid, mode, block_in_mcu, sample_index, sample_value,
                    output ready);
endinterface

FILE: rtl/core/jmucc_out_if.sv
// Pixel output channel: valid/ready handshake with one RGB pixel as payload.
interface jmucc_out_if;
    logic                          valid;
    logic                          ready;
    logic [jmucc_pkg::COORD_W-1:0] pixel_x;
    logic [jmucc_pkg::COORD_W-1:0] pixel_y;
    logic [jmucc_pkg::CH_W-1:0]    red;
    logic [jmucc_pkg::CH_W-1:0]    green;
    logic [jmucc_pkg::CH_W-1:0]    blue;

    modport source (output valid, pixel_x, pixel_y, red, green, blue, input ready);
    modport sink   (input valid, pixel_x, pixel_y, red, green, blue, output ready);
endinterface

FILE: rtl/core/jmucc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module jmucc_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/jmucc_front.sv
// Configuration registers, MCU origin tracking, chroma addressing and pixel placement.
module jmucc_front (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_cfg_we,
    input  logic [jmucc_pkg::CFG_IDX_W-1:0]          i_cfg_idx,
    input  logic [jmucc_pkg::CFG_DATA_W-1:0]         i_cfg_data,
    input  logic                                     i_accept,
    input  logic [1:0]                               i_mode,
    input  logic [1:0]                               i_block_in_mcu,
    input  logic [jmucc_pkg::IDX_W-1:0]              i_sample_index,
    input  logic signed [jmucc_pkg::SAMPLE_BITS-1:0] i_sample_value,
    output jmucc_pkg::t_mem_req                      o_mem,
    output jmucc_pkg::t_pix                          o_pix
);

    localparam int CW  = jmucc_pkg::COORD_W;
    localparam int BB  = jmucc_pkg::BLK_BITS;
    localparam logic [CW:0] MCU_NARROW = (CW + 1)'(jmucc_pkg::BLOCK_SIDE);
    localparam logic [CW:0] MCU_WIDE   = (CW + 1)'(2 * jmucc_pkg::BLOCK_SIDE);

    logic [jmucc_pkg::SS_W-1:0] r_subsampling;
    logic [CW-1:0]              r_width;
    logic [CW-1:0]              r_height;
    logic [CW-1:0]              r_origin_x;
    logic [CW-1:0]              r_origin_y;
    logic [CW-1:0]              n_origin_x;
    logic [CW-1:0]              n_origin_y;

    logic [BB-1:0]              row;
    logic [BB-1:0]              col;
    logic                       bx;
    logic                       by;
    logic                       wide;
    logic                       tall;
    logic [1:0]                 last_blk;
    logic [1:0]                 blk_eff;
    logic [jmucc_pkg::IDX_W-1:0] cidx;
    logic                       luma;
    logic                       mcu_end;
    logic [CW:0]                px;
    logic [CW:0]                py;
    logic [CW:0]                nx;
    logic [CW:0]                ny;

    assign row = i_sample_index[jmucc_pkg::IDX_W-1:BB];
    assign col = i_sample_index[BB-1:0];

    always_comb begin
        bx       = 1'b0;
        by       = 1'b0;
        wide     = 1'b0;
        tall     = 1'b0;
        last_blk = 2'd0;
        blk_eff  = i_block_in_mcu;
        cidx     = i_sample_index;
        case (r_subsampling)
            jmucc_pkg::SS_422H: begin
                bx       = i_block_in_mcu[0];
                wide     = 1'b1;
                last_blk = 2'd1;
                cidx     = {row, i_block_in_mcu[0], col[BB-1:1]};
            end
            jmucc_pkg::SS_422V: begin
                by       = i_block_in_mcu[0];
                tall     = 1'b1;
                last_blk = 2'd1;
                cidx     = {i_block_in_mcu[0], row[BB-1:1], col};
            end
            jmucc_pkg::SS_420: begin
                bx       = i_block_in_mcu[0];
                by       = i_block_in_mcu[1];
                wide     = 1'b1;
                tall     = 1'b1;
                last_blk = 2'd3;
                cidx     = {i_block_in_mcu[1], row[BB-1:1], i_block_in_mcu[0], col[BB-1:1]};
            end
            default: begin
                blk_eff = 2'd0;
            end
        endcase
    end

    assign luma    = (i_mode == jmucc_pkg::MODE_LUMA) && (r_subsampling <= jmucc_pkg::SS_GRAY);
    assign mcu_end = luma && (i_sample_index == '1) && (blk_eff == last_blk);

    assign px = {1'b0, r_origin_x} + (CW + 1)'({bx, col});
    assign py = {1'b0, r_origin_y} + (CW + 1)'({by, row});

    assign o_pix.valid = luma && (px < {1'b0, r_width}) && (py < {1'b0, r_height});
    assign o_pix.gray  = (r_subsampling == jmucc_pkg::SS_GRAY);
    assign o_pix.x     = px[CW-1:0];
    assign o_pix.y     = py[CW-1:0];
    assign o_pix.value = i_sample_value;

    assign o_mem.wr_cb = i_accept && (i_mode == jmucc_pkg::MODE_CB);
    assign o_mem.wr_cr = i_accept && (i_mode == jmucc_pkg::MODE_CR);
    assign o_mem.waddr = i_sample_index;
    assign o_mem.wdata = i_sample_value;
    assign o_mem.raddr = cidx;

    // step to the next MCU in raster order, wrap at the image edges
    assign nx = {1'b0, r_origin_x} + (wide ? MCU_WIDE : MCU_NARROW);
    assign ny = {1'b0, r_origin_y} + (tall ? MCU_WIDE : MCU_NARROW);

    always_comb begin
        n_origin_x = r_origin_x;
        n_origin_y = r_origin_y;
        if (i_accept && mcu_end) begin
            if (nx >= {1'b0, r_width}) begin
                n_origin_x = '0;
                if (ny >= {1'b0, r_height}) begin
                    n_origin_y = '0;
                end else begin
                    n_origin_y = ny[CW-1:0];
                end
            end else begin
                n_origin_x = nx[CW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_subsampling <= jmucc_pkg::SS_444;
            r_width       <= jmucc_pkg::DIM_RESET;
            r_height      <= jmucc_pkg::DIM_RESET;
            r_origin_x    <= '0;
            r_origin_y    <= '0;
        end else begin
            r_origin_x <= n_origin_x;
            r_origin_y <= n_origin_y;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    jmucc_pkg::CFG_SUBSAMPLING:  r_subsampling <= i_cfg_data[jmucc_pkg::SS_W-1:0];
                    jmucc_pkg::CFG_IMAGE_WIDTH:  r_width       <= i_cfg_data[CW-1:0];
                    jmucc_pkg::CFG_IMAGE_HEIGHT: r_height      <= i_cfg_data[CW-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

endmodule

FILE: rtl/core/jmucc_conv.sv
// Three-stage color conversion pipeline: chroma fetch, Q16 products, sum and clamp.
module jmucc_conv (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  jmucc_pkg::t_pix                          i_pix,
    input  logic signed [jmucc_pkg::SAMPLE_BITS-1:0] i_cb,
    input  logic signed [jmucc_pkg::SAMPLE_BITS-1:0] i_cr,
    output logic                                     o_advance,
    jmucc_out_if.source                              o_out
);

    localparam int SB = jmucc_pkg::SAMPLE_BITS;
    localparam int PW = jmucc_pkg::PROD_W;
    localparam int SW = jmucc_pkg::SUM_W;

    logic adv1;
    logic adv2;
    logic adv_out;

    // stage 1: pixel info, chroma arrives from the RAMs
    logic            r_v1;
    jmucc_pkg::t_pix r_s1;

    // stage 2: products
    logic                          r_v2;
    logic [jmucc_pkg::COORD_W-1:0] r_x2;
    logic [jmucc_pkg::COORD_W-1:0] r_y2;
    logic signed [SB:0]            r_base;
    logic signed [PW-1:0]          r_p_r;
    logic signed [PW-1:0]          r_p_gb;
    logic signed [PW-1:0]          r_p_gr;
    logic signed [PW-1:0]          r_p_b;
    logic signed [SB-1:0]          cb_eff;
    logic signed [SB-1:0]          cr_eff;
    logic signed [SB:0]            n_base;
    logic signed [PW-1:0]          n_p_r;
    logic signed [PW-1:0]          n_p_gb;
    logic signed [PW-1:0]          n_p_gr;
    logic signed [PW-1:0]          n_p_b;

    // output register
    logic                          r_out_valid;
    logic [jmucc_pkg::COORD_W-1:0] r_px;
    logic [jmucc_pkg::COORD_W-1:0] r_py;
    logic [jmucc_pkg::CH_W-1:0]    r_red;
    logic [jmucc_pkg::CH_W-1:0]    r_green;
    logic [jmucc_pkg::CH_W-1:0]    r_blue;
    logic signed [SW-1:0]          base_q;
    logic signed [SW-1:0]          sum_r;
    logic signed [SW-1:0]          sum_g;
    logic signed [SW-1:0]          sum_b;

    // each stage moves when it is empty or the next one moves
    assign adv_out   = !r_out_valid || o_out.ready;
    assign adv2      = !r_v2 || adv_out;
    assign adv1      = !r_v1 || adv2;
    assign o_advance = adv1;

    // gray: zero chroma leaves clamp(Y + 128)
    assign cb_eff = r_s1.gray ? '0 : i_cb;
    assign cr_eff = r_s1.gray ? '0 : i_cr;
    assign n_base = $signed({r_s1.value[SB-1], r_s1.value}) + jmucc_pkg::Y_OFFSET;
    assign n_p_r  = jmucc_pkg::Q_CR_R * cr_eff;
    assign n_p_gb = jmucc_pkg::Q_CB_G * cb_eff;
    assign n_p_gr = jmucc_pkg::Q_CR_G * cr_eff;
    assign n_p_b  = jmucc_pkg::Q_CB_B * cb_eff;

    assign base_q = SW'(r_base) <<< jmucc_pkg::FRAC;
    assign sum_r  = base_q + SW'(r_p_r);
    assign sum_g  = base_q - SW'(r_p_gb) - SW'(r_p_gr);
    assign sum_b  = base_q + SW'(r_p_b);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (adv1) begin
                r_v1 <= i_pix.valid;
            end
            if (adv2) begin
                r_v2 <= r_v1;
            end
            if (adv_out) begin
                r_out_valid <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv1) begin
            r_s1 <= i_pix;
        end
        if (adv2) begin
            r_x2   <= r_s1.x;
            r_y2   <= r_s1.y;
            r_base <= n_base;
            r_p_r  <= n_p_r;
            r_p_gb <= n_p_gb;
            r_p_gr <= n_p_gr;
            r_p_b  <= n_p_b;
        end
        if (adv_out) begin
            r_px    <= r_x2;
            r_py    <= r_y2;
            r_red   <= jmucc_pkg::clamp_q16(sum_r);
            r_green <= jmucc_pkg::clamp_q16(sum_g);
            r_blue  <= jmucc_pkg::clamp_q16(sum_b);
        end
    end

    assign o_out.valid   = r_out_valid;
    assign o_out.pixel_x = r_px;
    assign o_out.pixel_y = r_py;
    assign o_out.red     = r_red;
    assign o_out.green   = r_green;
    assign o_out.blue    = r_blue;

endmodule

FILE: rtl/core/jpeg_mcu_upsample_color_convert.sv
// Top level: JPEG MCU chroma upsampling and YCbCr to RGB conversion.
//
// Takes one decoded, level-shifted sample per cycle. Cb and Cr samples of an
// MCU go into two 64-entry chroma RAMs (one write port and one read port each);
// each luma sample then reads the nearest chroma entry for the configured
// subsampling and produces one RGB pixel at its image position, or nothing if
// that position lies outside the configured image. Gray mode outputs Y+128 on
// all channels. The MCU origin advances on its own in raster order after the
// last sample of the last luma block of each MCU. One item is accepted every
// cycle unless an output stall holds the input; a pixel passes the chroma RAM
// read at the edge that accepts its luma sample, then the coefficient multiply,
// then the sum and clamp. While a finished pixel waits on the output the input
// keeps accepting only until the two stages behind it are full; from then on an
// output stall holds the input. Chroma entries must be written before a luma
// sample reads them; there is no RAM clear after reset. Write configuration
// only while the block is idle.
module jpeg_mcu_upsample_color_convert (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [jmucc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [jmucc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    jmucc_in_if.sink                         i_in,
    jmucc_out_if.source                      o_out
);

    localparam int SB = jmucc_pkg::SAMPLE_BITS;

    logic                 accept;
    logic                 advance;
    jmucc_pkg::t_mem_req  mem;
    jmucc_pkg::t_pix      pix;
    logic signed [SB-1:0] cb_rdata;
    logic signed [SB-1:0] cr_rdata;

    assign i_in.ready = advance;
    assign accept     = i_in.valid && advance;

    jmucc_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_accept       (accept),
        .i_mode         (i_in.mode),
        .i_block_in_mcu (i_in.block_in_mcu),
        .i_sample_index (i_in.sample_index),
        .i_sample_value (i_in.sample_value),
        .o_mem          (mem),
        .o_pix          (pix)
    );

    jmucc_ram #(
        .WIDTH (SB),
        .DEPTH (jmucc_pkg::STORE_DEPTH)
    ) u_cb_ram (
        .i_clk   (i_clk),
        .i_we    (mem.wr_cb),
        .i_waddr (mem.waddr),
        .i_wdata (mem.wdata),
        .i_re    (advance),
        .i_raddr (mem.raddr),
        .o_rdata (cb_rdata)
    );

    jmucc_ram #(
        .WIDTH (SB),
        .DEPTH (jmucc_pkg::STORE_DEPTH)
    ) u_cr_ram (
        .i_clk   (i_clk),
        .i_we    (mem.wr_cr),
        .i_waddr (mem.waddr),
        .i_wdata (mem.wdata),
        .i_re    (advance),
        .i_raddr (mem.raddr),
        .o_rdata (cr_rdata)
    );

    // gate the pixel with the handshake so bubbles enter the pipeline
    jmucc_pkg::t_pix pix_acc;

    always_comb begin
        pix_acc       = pix;
        pix_acc.valid = pix.valid && accept;
    end

    jmucc_conv u_conv (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_pix     (pix_acc),
        .i_cb      (cb_rdata),
        .i_cr      (cr_rdata),
        .o_advance (advance),
        .o_out     (o_out)
    );

endmodule

FILE: verif/jpeg_mcu_upsample_color_convert_checker.sv
// Checker: follows register writes and sample transactions, predicts each RGB pixel and compares.
`timescale 1ns / 100ps
module jpeg_mcu_upsample_color_convert_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [jmucc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [jmucc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    jmucc_in_if                              i_samples,
    jmucc_out_if                             i_pixels,
    output int                               o_errors,
    output int                               o_pending
);

    localparam int SB    = jmucc_pkg::SAMPLE_BITS;
    localparam int CW    = jmucc_pkg::COORD_W;
    localparam int CHW   = jmucc_pkg::CH_W;
    localparam int SSW   = jmucc_pkg::SS_W;
    localparam int IW    = jmucc_pkg::IDX_W;
    localparam int BS    = jmucc_pkg::BLOCK_SIDE;
    localparam int DEPTH = jmucc_pkg::STORE_DEPTH;

    localparam longint K_CR_R  = 91881;
    localparam longint K_CB_G  = 22553;
    localparam longint K_CR_G  = 46802;
    localparam longint K_CB_B  = 116130;
    localparam longint ONE_Q16 = 65536;

    typedef struct packed {
        logic [CW-1:0]  x;
        logic [CW-1:0]  y;
        logic [CHW-1:0] r;
        logic [CHW-1:0] g;
        logic [CHW-1:0] b;
    } t_pixel;

    logic signed [SB-1:0] cb_store [DEPTH];
    logic signed [SB-1:0] cr_store [DEPTH];
    int unsigned          mcu_x;
    int unsigned          mcu_y;
    logic [SSW-1:0]       cur_ss;
    logic [CW-1:0]        cur_width;
    logic [CW-1:0]        cur_height;
    t_pixel               expected_pixels [$];
    int                   errors = 0;

    assign o_errors = errors;

    function automatic logic [CHW-1:0] q16_to_channel(input longint sum);
        longint whole;
        if (sum < 0) begin
            return '0;
        end
        whole = sum / ONE_Q16;
        return (whole > 255) ? jmucc_pkg::CH_MAX : CHW'(whole);
    endfunction

    function automatic logic [CHW-1:0] gray_channel(input int level);
        if (level < 0) begin
            return '0;
        end
        return (level > 255) ? jmucc_pkg::CH_MAX : CHW'(level);
    endfunction

    // Store chroma, or turn one luma sample into the pixel it lands on and move the MCU origin.
    task automatic convert_sample(input logic [1:0] mode, input logic [1:0] blk,
                                  input logic [IW-1:0] idx,
                                  input logic signed [SB-1:0] level);
        int unsigned row, col, bx, by, blk_no, last_blk, mcu_w, mcu_h, cidx, px, py;
        longint      luma_q, cb, cr;
        t_pixel      pix;
        row      = idx / BS;
        col      = idx % BS;
        bx       = 0;
        by       = 0;
        blk_no   = blk;
        last_blk = 0;
        mcu_w    = BS;
        mcu_h    = BS;
        cidx     = idx;
        if (mode == jmucc_pkg::MODE_CB) begin
            cb_store[idx] = level;
        end else if (mode == jmucc_pkg::MODE_CR) begin
            cr_store[idx] = level;
        end else if (mode == jmucc_pkg::MODE_LUMA && cur_ss <= jmucc_pkg::SS_GRAY) begin
            case (cur_ss)
                jmucc_pkg::SS_422H: begin
                    bx       = blk_no % 2;
                    last_blk = 1;
                    mcu_w    = 2 * BS;
                    cidx     = row * 8 + col / 2 + 4 * bx;
                end
                jmucc_pkg::SS_422V: begin
                    by       = blk_no % 2;
                    last_blk = 1;
                    mcu_h    = 2 * BS;
                    cidx     = (row / 2 + 4 * by) * 8 + col;
                end
                jmucc_pkg::SS_420: begin
                    bx       = blk_no % 2;
                    by       = blk_no / 2;
                    last_blk = 3;
                    mcu_w    = 2 * BS;
                    mcu_h    = 2 * BS;
                    cidx     = (row / 2 + 4 * by) * 8 + col / 2 + 4 * bx;
                end
                default: blk_no = 0;
            endcase
            cidx = cidx % DEPTH;
            px   = mcu_x + bx * BS + col;
            py   = mcu_y + by * BS + row;
            if (px < cur_width && py < cur_height) begin
                pix.x = CW'(px);
                pix.y = CW'(py);
                if (cur_ss == jmucc_pkg::SS_GRAY) begin
                    pix.r = gray_channel(int'(level) + 128);
                    pix.g = pix.r;
                    pix.b = pix.r;
                end else begin
                    cb     = cb_store[cidx];
                    cr     = cr_store[cidx];
                    luma_q = (longint'(level) + 128) * ONE_Q16;
                    pix.r  = q16_to_channel(luma_q + K_CR_R * cr);
                    pix.g  = q16_to_channel(luma_q - K_CB_G * cb - K_CR_G * cr);
                    pix.b  = q16_to_channel(luma_q + K_CB_B * cb);
                end
                expected_pixels.push_back(pix);
            end
            // last sample of the last block closes the MCU
            if (idx == DEPTH - 1 && blk_no == last_blk) begin
                mcu_x += mcu_w;
                if (mcu_x >= cur_width) begin
                    mcu_x = 0;
                    mcu_y += mcu_h;
                    if (mcu_y >= cur_height) begin
                        mcu_y = 0;
                    end
                end
            end
        end
    endtask

    task automatic compare_field(input string field, input logic [CW-1:0] want,
                                 input logic [CW-1:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        end
    endtask

    task automatic check_pixel();
        t_pixel want;
        if (expected_pixels.size() == 0) begin
            errors++;
            $display("%0t: pixel with none expected, expected nothing, actual (%0d,%0d)",
                     $time, i_pixels.pixel_x, i_pixels.pixel_y);
            return;
        end
        want = expected_pixels.pop_front();
        compare_field("pixel_x", want.x, i_pixels.pixel_x);
        compare_field("pixel_y", want.y, i_pixels.pixel_y);
        compare_field("red", want.r, i_pixels.red);
        compare_field("green", want.g, i_pixels.green);
        compare_field("blue", want.b, i_pixels.blue);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            mcu_x      = 0;
            mcu_y      = 0;
            cur_ss     = jmucc_pkg::SS_444;
            cur_width  = jmucc_pkg::DIM_RESET;
            cur_height = jmucc_pkg::DIM_RESET;
            expected_pixels.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    jmucc_pkg::CFG_SUBSAMPLING:  cur_ss     = i_cfg_data[SSW-1:0];
                    jmucc_pkg::CFG_IMAGE_WIDTH:  cur_width  = i_cfg_data;
                    jmucc_pkg::CFG_IMAGE_HEIGHT: cur_height = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_pixels.valid && i_pixels.ready) begin
                check_pixel();
            end
            if (i_samples.valid && i_samples.ready) begin
                convert_sample(i_samples.mode, i_samples.block_in_mcu, i_samples.sample_index,
                               i_samples.sample_value);
            end
        end
        o_pending <= expected_pixels.size();
    end

endmodule

FILE: verif/jpeg_mcu_upsample_color_convert_tb.sv
// Testbench top: clock, reset, register writes, sample stimulus, output stalls and verdict.
`timescale 1ns / 100ps
module jpeg_mcu_upsample_color_convert_tb;

    localparam int SB    = jmucc_pkg::SAMPLE_BITS;
    localparam int CW    = jmucc_pkg::COORD_W;
    localparam int SSW   = jmucc_pkg::SS_W;
    localparam int IW    = jmucc_pkg::IDX_W;
    localparam int DEPTH = jmucc_pkg::STORE_DEPTH;

    localparam int RANDOM_ITEMS  = 340;
    localparam int QUIET_AFTER   = 280;
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT   = 400000;

    localparam logic [1:0]    MODE_UNUSED     = 2'd3;
    localparam logic [SSW-1:0] SS_RESERVED_MIN = 3'd5;
    localparam logic [SSW-1:0] SS_RESERVED_MAX = 3'd7;
    localparam logic [SB-1:0] SAMPLE_MIN      = 12'h800;
    localparam logic [SB-1:0] SAMPLE_MAX      = 12'h7FF;

    logic                             clk;
    logic                             rst_n;
    logic                             cfg_we;
    logic [jmucc_pkg::CFG_IDX_W-1:0]  cfg_idx;
    logic [jmucc_pkg::CFG_DATA_W-1:0] cfg_data;
    int                               cycle_count   = 0;
    int                               counted_items = 0;
    logic                             quiet         = 1'b0;
    logic [SSW-1:0]                   tb_ss         = jmucc_pkg::SS_444;
    int                               checker_errors;
    int                               checker_pending;

    jmucc_in_if  sample_ch ();
    jmucc_out_if pixel_ch ();

    jpeg_mcu_upsample_color_convert i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in       (sample_ch),
        .o_out      (pixel_ch)
    );

    jpeg_mcu_upsample_color_convert_checker u_checker (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_samples  (sample_ch),
        .i_pixels   (pixel_ch),
        .o_errors   (checker_errors),
        .o_pending  (checker_pending)
    );

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Output side: ready runs high, dropping in random bursts until the quiet tail.
    initial begin : pixel_ready_gen
        int run_len;
        pixel_ch.ready <= 1'b0;
        @(posedge clk);
        forever begin
            pixel_ch.ready <= 1'b1;
            run_len = $urandom_range(1, 40);
            repeat (run_len) @(posedge clk);
            if (!quiet && $urandom_range(0, 2) == 0) begin
                pixel_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge clk);
            end
        end
    end

    // Mostly values near the useful range, now and then any 12-bit value.
    function automatic logic [SB-1:0] rand_sample();
        if ($urandom_range(0, 3) == 0) begin
            return SB'($urandom_range(0, 2 ** SB - 1));
        end
        return SB'($urandom_range(0, 320) - 160);
    endfunction

    function automatic logic [CW-1:0] pick_dim();
        case ($urandom_range(0, 9))
            0:       return CW'(1);
            1:       return '1;
            default: return CW'($urandom_range(1, 48));
        endcase
    endfunction

    task automatic set_config(input logic [SSW-1:0] ss, input logic [CW-1:0] width,
                              input logic [CW-1:0] height);
        cfg_we   <= 1'b1;
        cfg_idx  <= jmucc_pkg::CFG_SUBSAMPLING;
        cfg_data <= jmucc_pkg::CFG_DATA_W'(ss);
        @(posedge clk);
        cfg_idx  <= jmucc_pkg::CFG_IMAGE_WIDTH;
        cfg_data <= width;
        @(posedge clk);
        cfg_idx  <= jmucc_pkg::CFG_IMAGE_HEIGHT;
        cfg_data <= height;
        @(posedge clk);
        cfg_we   <= 1'b0;
        tb_ss = ss;
    endtask

    task automatic send_sample(input logic [1:0] mode, input logic [1:0] blk,
                               input logic [IW-1:0] idx,
                               input logic [SB-1:0] value);
        if (!quiet && $urandom_range(0, 7) == 0) begin
            sample_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        sample_ch.valid        <= 1'b1;
        sample_ch.mode         <= mode;
        sample_ch.block_in_mcu <= blk;
        sample_ch.sample_index <= idx;
        sample_ch.sample_value <= value;
        do @(posedge clk); while (!sample_ch.ready);
        if (mode != MODE_UNUSED &&
            !(mode == jmucc_pkg::MODE_LUMA && tb_ss > jmucc_pkg::SS_GRAY)) begin
            counted_items++;
        end
        if (counted_items >= QUIET_AFTER) begin
            quiet = 1'b1;
        end
    endtask

    // Hold until every expected pixel is out, then let the pipeline empty.
    task automatic drain();
        sample_ch.valid <= 1'b0;
        do @(negedge clk); while (checker_pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic send_noise();
        case ($urandom_range(0, 2))
            0: send_sample(MODE_UNUSED, 2'($urandom_range(0, 3)), IW'($urandom_range(0, 63)),
                           rand_sample());
            1: send_sample($urandom_range(0, 1) ? jmucc_pkg::MODE_CB : jmucc_pkg::MODE_CR,
                           2'($urandom_range(0, 3)), IW'($urandom_range(0, 63)),
                           rand_sample());
            default: send_sample(jmucc_pkg::MODE_LUMA, 2'($urandom_range(0, 3)),
                                 IW'($urandom_range(0, 63)), rand_sample());
        endcase
    endtask

    // One MCU: a few fresh chroma entries, then its luma blocks, sparse or complete.
    task automatic send_mcu();
        int         last_blk;
        int         keep_pct;
        int         n_chroma;
        logic [1:0] blk;
        last_blk = (tb_ss == jmucc_pkg::SS_420) ? 3 :
                   (tb_ss == jmucc_pkg::SS_422H || tb_ss == jmucc_pkg::SS_422V) ? 1 : 0;
        keep_pct = ($urandom_range(0, 5) == 0) ? 100 : 25;
        n_chroma = $urandom_range(0, 12);
        repeat (n_chroma) begin
            send_sample(jmucc_pkg::MODE_CB, 2'd0, IW'($urandom_range(0, 63)), rand_sample());
        end
        repeat (n_chroma) begin
            send_sample(jmucc_pkg::MODE_CR, 2'd0, IW'($urandom_range(0, 63)), rand_sample());
        end
        for (int b = 0; b <= last_blk; b++) begin
            for (int k = 0; k < DEPTH; k++) begin
                if (k == DEPTH - 1 || $urandom_range(1, 100) <= keep_pct) begin
                    if ($urandom_range(0, 15) == 0) begin
                        send_noise();
                    end
                    // block number is don't-care for single-block MCUs
                    blk = (last_blk == 0) ? 2'($urandom_range(0, 3)) : 2'(b);
                    send_sample(jmucc_pkg::MODE_LUMA, blk, IW'(k), rand_sample());
                end
            end
        end
    endtask

    initial begin : stimulus
        logic [SSW-1:0] ss;
        int             phase_mcus;
        rst_n                  <= 1'b0;
        cfg_we                 <= 1'b0;
        cfg_idx                <= jmucc_pkg::CFG_SUBSAMPLING;
        cfg_data               <= '0;
        sample_ch.valid        <= 1'b0;
        sample_ch.mode         <= jmucc_pkg::MODE_LUMA;
        sample_ch.block_in_mcu <= '0;
        sample_ch.sample_index <= '0;
        sample_ch.sample_value <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // fill both chroma stores so no luma sample reads an unwritten entry
        for (int k = 0; k < DEPTH; k++) begin
            send_sample(jmucc_pkg::MODE_CB, 2'd0, IW'(k),
                        (k == 0) ? SAMPLE_MIN : (k == 1) ? SAMPLE_MAX : rand_sample());
            send_sample(jmucc_pkg::MODE_CR, 2'd0, IW'(k),
                        (k == 0) ? SAMPLE_MAX : (k == 1) ? SAMPLE_MIN : rand_sample());
        end
        drain();

        // 4:4:4 with extreme luma, plus an unused mode
        set_config(jmucc_pkg::SS_444, jmucc_pkg::DIM_RESET, jmucc_pkg::DIM_RESET);
        send_sample(jmucc_pkg::MODE_LUMA, 2'd3, 6'd0, SAMPLE_MAX);
        send_sample(jmucc_pkg::MODE_LUMA, 2'd0, 6'd9, SAMPLE_MIN);
        send_sample(jmucc_pkg::MODE_LUMA, 2'd1, 6'd18, 12'd0);
        send_sample(MODE_UNUSED, 2'd3, 6'd63, SAMPLE_MAX);
        drain();

        // partial edge block: outside pixels drop, origin wraps both ways
        set_config(jmucc_pkg::SS_444, 16'd4, 16'd4);
        send_sample(jmucc_pkg::MODE_LUMA, 2'd0, 6'd5, 12'd100);
        send_sample(jmucc_pkg::MODE_LUMA, 2'd0, 6'd63, 12'd50);
        send_sample(jmucc_pkg::MODE_LUMA, 2'd0, 6'd0, 12'd20);
        drain();

        // gray, including chroma written while in gray
        set_config(jmucc_pkg::SS_GRAY, 16'd16, 16'd16);
        send_sample(jmucc_pkg::MODE_LUMA, 2'd0, 6'd0, SAMPLE_MAX);
        send_sample(jmucc_pkg::MODE_LUMA, 2'd0, 6'd1, SAMPLE_MIN);
        send_sample(jmucc_pkg::MODE_LUMA, 2'd0, 6'd2, 12'hF7F);
        send_sample(jmucc_pkg::MODE_LUMA, 2'd0, 6'd3, 12'd127);
        send_sample(jmucc_pkg::MODE_CB, 2'd0, 6'd10, rand_sample());
        send_sample(jmucc_pkg::MODE_LUMA, 2'd2, 6'd63, 12'd0);
        drain();

        // widest and narrowest images
        set_config(jmucc_pkg::SS_420, '1, 16'd1);
        send_sample(jmucc_pkg::MODE_LUMA, 2'd3, 6'd0, 12'd10);
        send_sample(jmucc_pkg::MODE_LUMA, 2'd0, 6'd7, 12'd30);
        drain();
        set_config(jmucc_pkg::SS_422V, 16'd1, '1);
        send_sample(jmucc_pkg::MODE_LUMA, 2'd1, 6'd8, 12'd40);
        send_sample(jmucc_pkg::MODE_LUMA, 2'd1, 6'd63, 12'd60);
        send_sample(jmucc_pkg::MODE_LUMA, 2'd0, 6'd8, 12'd70);
        drain();

        // reserved subsampling: luma dropped, chroma still stored
        set_config(SS_RESERVED_MAX, jmucc_pkg::DIM_RESET, jmucc_pkg::DIM_RESET);
        send_sample(jmucc_pkg::MODE_LUMA, 2'd0, 6'd63, 12'd5);
        send_sample(jmucc_pkg::MODE_CR, 2'd0, 6'd20, rand_sample());
        drain();

        counted_items = 0;
        while (counted_items < RANDOM_ITEMS) begin
            if ($urandom_range(0, 9) == 0) begin
                ss = SSW'($urandom_range(SS_RESERVED_MIN, SS_RESERVED_MAX));
            end else begin
                ss = SSW'($urandom_range(jmucc_pkg::SS_444, jmucc_pkg::SS_GRAY));
            end
            set_config(ss, pick_dim(), pick_dim());
            phase_mcus = $urandom_range(2, 6);
            repeat (phase_mcus) begin
                if (counted_items < RANDOM_ITEMS) begin
                    send_mcu();
                end
            end
            drain();
        end

        if (checker_errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
